@@ hw/rtl/imh_pkg.sv @@
`default_nettype none
package imh_pkg;
	localparam int CAPACITY    = 256;
	localparam int SLOT_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int ID_BITS     = 8;
	localparam int ID_COUNT    = 256;
	localparam int WEIGHT_BITS = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// one queued command between front and back
	typedef struct packed {
		logic [1:0]                    op;
		logic [ID_BITS-1:0]            id;
		logic signed [WEIGHT_BITS-1:0] weight;
	} cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/imh_front.sv @@
`default_nettype none
// input skid queue: takes words while the back end is busy
module imh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire imh_pkg::cmd_t in_cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output imh_pkg::cmd_t      cmd
);
	localparam int PB = $clog2(imh_pkg::QUEUE_DEPTH);
	imh_pkg::cmd_t   fifo_q [imh_pkg::QUEUE_DEPTH];
	logic [PB-1:0]   wr_q, rd_q;
	logic [PB:0]     cnt_q;
	logic push, pop;

	assign in_ready  = cnt_q != (PB+1)'(imh_pkg::QUEUE_DEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = fifo_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PB'(1);
			if (pop)  rd_q <= rd_q + PB'(1);
			cnt_q <= cnt_q + (PB+1)'(push) - (PB+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/imh_back.sv @@
`default_nettype none
// heap engine: one command at a time, sift by level through the memories
module imh_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	output logic                           cmd_ready,
	input  wire imh_pkg::cmd_t             cmd,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     status,
	output logic [imh_pkg::ID_BITS-1:0]    min_id,
	output logic signed [imh_pkg::WEIGHT_BITS-1:0] min_weight,
	output logic                           min_valid,
	output logic                           heap_empty,
	output logic [imh_pkg::COUNT_BITS-1:0] element_count
);
	localparam int SB = imh_pkg::SLOT_BITS;
	localparam int CB = imh_pkg::COUNT_BITS;
	localparam int IB = imh_pkg::ID_BITS;
	localparam int WB = imh_pkg::WEIGHT_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_LOOK, S_LOOKW, S_INS, S_RDROOT, S_RDROOTW, S_RDLAST, S_RDLASTW,
		S_FILL, S_DN_IN, S_DN_RD, S_DN_LW, S_DN_L, S_DN_R, S_DN_W, S_DN_SW,
		S_UP_RD, S_UP_P, S_UP_PW, S_UP_SW, S_FIN, S_FINW, S_FINR, S_OUT
	} state_t;
	state_t state_q;

	logic [1:0]           cmd_op_q;
	logic [IB-1:0]        cmd_id_q;
	logic signed [WB-1:0] cmd_w_q;
	logic [CB-1:0]        count_q;
	logic [SB-1:0]        k_q, c_q;
	logic [IB-1:0]        kid_q, cid_q, lid_q, rid_q;
	logic signed [WB-1:0] kw_q, cw_q;
	logic                 up_after_q;
	logic [2:0]           st_q;
	logic                 have_q;
	logic [IB-1:0]        mid_q;
	logic signed [WB-1:0] mw_q;

	// memories
	logic [IB-1:0]        heap_mem [imh_pkg::CAPACITY];
	logic [SB-1:0]        pos_mem  [imh_pkg::ID_COUNT];
	logic signed [WB-1:0] wt_mem   [imh_pkg::ID_COUNT];
	logic [imh_pkg::ID_COUNT-1:0] present_q;

	logic [SB-1:0] h_ra, h_wa; logic [IB-1:0] h_wd, h_rd; logic h_we;
	logic [IB-1:0] p_ra, p_wa; logic [SB-1:0] p_wd, p_rd; logic p_we;
	logic [IB-1:0] w_ra; logic signed [WB-1:0] w_rd;

	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		h_rd <= heap_mem[h_ra];
	end
	always_ff @(posedge clk) begin
		if (p_we) pos_mem[p_wa] <= p_wd;
		p_rd <= pos_mem[p_ra];
	end
	always_ff @(posedge clk) begin
		if (state_q == S_INS) wt_mem[cmd_id_q] <= cmd_w_q;
		w_rd <= wt_mem[w_ra];
	end

	// child indexes as wide values so bounds work at the top slot
	logic [CB:0] lch, rch;
	assign lch = (CB+1)'({k_q, 1'b0}) + (CB+1)'(1);
	assign rch = lch + (CB+1)'(1);

	// memory port steering
	always_comb begin
		h_ra = '0; h_wa = '0; h_wd = '0; h_we = 1'b0;
		p_ra = cmd_id_q; p_wa = '0; p_wd = '0; p_we = 1'b0;
		w_ra = h_rd;
		unique case (state_q)
			S_IDLE:   p_ra = cmd.id;
			S_INS: begin
				h_we = 1'b1; h_wa = SB'(count_q); h_wd = cmd_id_q;
				p_we = 1'b1; p_wa = cmd_id_q; p_wd = SB'(count_q);
			end
			S_RDROOT: h_ra = '0;
			S_RDLAST: h_ra = SB'(count_q - CB'(1));
			S_FILL: begin
				h_we = 1'b1; h_wa = k_q; h_wd = lid_q;
				p_we = 1'b1; p_wa = lid_q; p_wd = k_q;
				w_ra = lid_q;
			end
			S_DN_RD:  h_ra = SB'(lch);
			S_DN_LW:  h_ra = SB'(rch);
			S_UP_RD:  h_ra = SB'((CB'(k_q) - CB'(1)) >> 1);
			S_DN_SW, S_UP_SW: begin
				h_we = 1'b1; h_wa = c_q; h_wd = kid_q;
				p_we = 1'b1; p_wa = kid_q; p_wd = c_q;
			end
			// child or parent moves into slot k only when a swap is due
			S_DN_W: if (cw_q < kw_q) begin
				h_we = 1'b1; h_wa = k_q; h_wd = cid_q;
				p_we = 1'b1; p_wa = cid_q; p_wd = k_q;
			end
			S_UP_PW: if (kw_q < w_rd) begin
				h_we = 1'b1; h_wa = k_q; h_wd = cid_q;
				p_we = 1'b1; p_wa = cid_q; p_wd = k_q;
			end
			S_FIN:    h_ra = '0;
			default: ;
		endcase
	end

	assign cmd_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign status = st_q;
	assign min_id = have_q ? mid_q : '0;
	assign min_weight = have_q ? mw_q : '0;
	assign min_valid = have_q;
	assign heap_empty = count_q == '0;
	assign element_count = count_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; present_q <= '0; count_q <= '0;
			st_q <= imh_pkg::ST_OK; have_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					cmd_op_q <= cmd.op; cmd_id_q <= cmd.id; cmd_w_q <= cmd.weight;
					st_q <= imh_pkg::ST_OK; have_q <= 1'b0;
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					kw_q <= cmd_w_q; kid_q <= cmd_id_q;
					priority case (cmd_op_q)
						imh_pkg::OP_INSERT:
							if (present_q[cmd_id_q]) begin
								st_q <= imh_pkg::ST_DUP; state_q <= S_FIN;
							end else if (count_q == CB'(imh_pkg::CAPACITY)) begin
								st_q <= imh_pkg::ST_FULL; state_q <= S_FIN;
							end else state_q <= S_INS;
						imh_pkg::OP_EXTRACT:
							if (count_q == '0) begin
								st_q <= imh_pkg::ST_EMPTY; state_q <= S_FIN;
							end else begin
								k_q <= '0; state_q <= S_RDROOT;
							end
						imh_pkg::OP_REMOVE:
							if (!present_q[cmd_id_q]) begin
								st_q <= imh_pkg::ST_NOTFOUND; state_q <= S_FIN;
							end else begin
								k_q <= p_rd; state_q <= S_RDLAST;
							end
						default: state_q <= S_FIN;
					endcase
				end
				S_INS: begin
					present_q[cmd_id_q] <= 1'b1;
					k_q <= SB'(count_q); count_q <= count_q + CB'(1);
					state_q <= S_UP_RD;
				end
				S_RDROOT: state_q <= S_RDROOTW;
				S_RDROOTW: state_q <= S_LOOKW;
				S_LOOKW: begin
					mid_q <= h_rd; mw_q <= w_rd; have_q <= 1'b1;
					present_q[h_rd] <= 1'b0; state_q <= S_RDLAST;
				end
				S_RDLAST: begin
					if (cmd_op_q == imh_pkg::OP_REMOVE) present_q[cmd_id_q] <= 1'b0;
					state_q <= S_RDLASTW;
				end
				S_RDLASTW: begin
					lid_q <= h_rd; count_q <= count_q - CB'(1);
					if (CB'(k_q) == count_q - CB'(1)) state_q <= S_FIN;
					else state_q <= S_FILL;
				end
				S_FILL: state_q <= S_DN_IN;
				// filler weight arrives, start sift-down at the hole
				S_DN_IN: begin
					kid_q <= lid_q; kw_q <= w_rd; up_after_q <= 1'b1;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (lch >= (CB+1)'(count_q)) state_q <= up_after_q ? S_UP_RD : S_FIN;
					else state_q <= S_DN_LW;
				end
				S_DN_LW: begin
					cid_q <= h_rd; c_q <= SB'(lch);
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					cw_q <= w_rd; rid_q <= h_rd;
					if (rch >= (CB+1)'(count_q)) state_q <= S_DN_W;
					else state_q <= S_DN_R;
				end
				S_DN_R: begin
					// left wins ties
					if (w_rd < cw_q) begin
						cid_q <= rid_q; cw_q <= w_rd; c_q <= SB'(rch);
					end
					state_q <= S_DN_W;
				end
				S_DN_W: begin
					if (cw_q < kw_q) begin
						up_after_q <= 1'b0; state_q <= S_DN_SW;
					end else if (up_after_q) state_q <= S_UP_RD;
					else state_q <= S_FIN;
				end
				S_DN_SW: begin
					k_q <= c_q;
					state_q <= S_DN_RD;
				end
				S_UP_RD: begin
					if (k_q == '0) state_q <= S_FIN;
					else begin
						c_q <= SB'((CB'(k_q) - CB'(1)) >> 1); state_q <= S_UP_P;
					end
				end
				S_UP_P: begin
					cid_q <= h_rd; state_q <= S_UP_PW;
				end
				S_UP_PW: begin
					if (kw_q < w_rd) state_q <= S_UP_SW;
					else state_q <= S_FIN;
				end
				S_UP_SW: begin k_q <= c_q; state_q <= S_UP_RD; end
				S_FIN: state_q <= S_FINW;
				S_FINW: state_q <= S_FINR;
				S_FINR: begin
					if (!have_q && count_q != '0) begin
						have_q <= 1'b1; mid_q <= h_rd; mw_q <= w_rd;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/indexed_min_heap.sv @@
`default_nettype none
// indexed binary min-heap, one word per command
// throughput: one command in the engine; the next starts once its result is taken
// reset: asynchronous, empties the heap and marks every id absent
module indexed_min_heap (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  element_id,
	input  wire logic signed [31:0] weight,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       min_id,
	output logic signed [31:0] min_weight,
	output logic             min_valid,
	output logic             heap_empty,
	output logic [8:0]       element_count
);
	imh_pkg::cmd_t in_cmd, cmd;
	logic cmd_valid, cmd_ready;

	assign in_cmd = '{op: operation, id: element_id, weight: weight};

	imh_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.cmd_valid, .cmd_ready, .cmd
	);

	imh_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .status, .min_id, .min_weight,
		.min_valid, .heap_empty, .element_count
	);
endmodule
`default_nettype wire

@@ hw/rtl/imh_checker.sv @@
`default_nettype none
module imh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [7:0]  min_id,
	input wire logic        min_valid,
	input wire logic        heap_empty,
	input wire logic [8:0]  element_count
);
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heap_empty == (element_count == 9'd0))) else $error("empty flag");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> element_count <= 9'd256) else $error("count overflow");
	a_nomin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !min_valid |-> min_id == 8'd0) else $error("stale min id");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
endmodule
bind indexed_min_heap imh_checker u_chk (.*);
`default_nettype wire
